// ===== src/bts_pkg.sv =====
`timescale 1ns / 1ps

package bts_pkg;

  // Widest frame the line buffer holds.
  localparam int MAX_WIDTH = 1024;

  // Line buffer address width: the buffer reaches back 2*width shifts.
  localparam int LINE_AW = $clog2(2 * MAX_WIDTH + 1);
  localparam int LINE_DEPTH = 1 << LINE_AW;

  // Fixed field widths.
  localparam int WIDTH_BITS = 11;
  localparam int HEIGHT_BITS = 12;
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SUBPASS_PARITY = 2'd2;

  // Reset values and limits.
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MIN = 11'd3;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN = 12'd3;

  // Thinning test constants.
  localparam logic [3:0] TRANS_ONE = 4'd1;
  localparam logic [3:0] COUNT_LOW = 4'd2;
  localparam logic [3:0] COUNT_HIGH = 4'd6;

  // The 3x3 window around the delayed pixel, after the latest shift.
  typedef struct packed {
    logic p2;
    logic p3;
    logic p4;
    logic p5;
    logic p6;
    logic p7;
    logic p8;
    logic p9;
    logic ctr;
  } bts_win_t;

endpackage

// ===== src/binary_thinning_subpass.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in_       sink       in_valid / in_ready     in_pixel_in, in_flush
// out_      source     out_valid / out_ready   out_pixel_out, out_removed,
//                                              out_frame_end, out_frame_changed
// cfg_      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One input transfer is taken every cycle while the decision stage is free or
// moving on; a result is registered in the decision stage, alongside the line
// buffer read register, and then in the output register.
// Reset clears the line buffer fill count, the raster counters and the
// window taps; the buffer memory itself is not cleared.
// A stalled output register holds the decision stage, which in turn holds
// in_ready low; out_ready reaches in_ready through combinational logic only.
// The configuration port is always ready.

module binary_thinning_subpass
  import bts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_pixel_in,
  input  logic                      in_flush,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_pixel_out,
  output logic                      out_removed,
  output logic                      out_frame_end,
  output logic                      out_frame_changed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Effective frame size, clamped when written.
  logic [WIDTH_BITS-1:0]  w_r;
  logic [HEIGHT_BITS-1:0] h_r;
  logic                   parity_r;
  logic [WIDTH_BITS-1:0]  w_nxt;
  logic [HEIGHT_BITS-1:0] h_nxt;

  // Pixels in flight (never more than width + 1) and the raster position
  // of the next pixel to leave.
  logic [WIDTH_BITS-1:0]  pend_r;
  logic [COL_BITS-1:0]    col_r;
  logic [HEIGHT_BITS-1:0] row_r;
  logic                   any_r;

  // Decision stage.
  logic s1_valid_r;
  logic s1_inner_r;
  logic s1_last_r;
  logic s1_go;

  // Output register.
  logic out_valid_r;
  logic pix_out_r;
  logic rem_out_r;
  logic end_out_r;
  logic chg_out_r;

  logic        in_xfer;
  logic        cfg_xfer;
  logic        size_write;
  logic        shift_en;
  logic        emit;
  logic        col_wrap;
  logic        row_wrap;
  logic        inner;
  logic [3:0]  trans;
  logic [3:0]  count;
  logic        m1;
  logic        m2;
  logic        rem;
  bts_win_t    win;

  assign cfg_ready  = 1'b1;
  assign cfg_xfer   = cfg_valid & cfg_ready;
  assign size_write = cfg_xfer &
                      ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  always_comb begin
    w_nxt = cfg_data[WIDTH_BITS-1:0];
    if (w_nxt < WIDTH_MIN) begin
      w_nxt = WIDTH_MIN;
    end else if (w_nxt > WIDTH_MAX) begin
      w_nxt = WIDTH_MAX;
    end
    h_nxt = cfg_data[HEIGHT_BITS-1:0];
    if (h_nxt < HEIGHT_MIN) begin
      h_nxt = HEIGHT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= WIDTH_RESET;
      h_r      <= HEIGHT_RESET;
      parity_r <= 1'b0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          w_r <= w_nxt;
        end
        REG_FRAME_HEIGHT: begin
          h_r <= h_nxt;
        end
        REG_SUBPASS_PARITY: begin
          parity_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // The decision stage moves on whenever the output register is free or
  // being emptied; a new transfer is taken whenever the stage is free then.
  assign s1_go    = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_go;
  assign in_xfer  = in_valid & in_ready;

  // A pixel always shifts in. A flush shifts in a zero only while pixels
  // are in flight. A result leaves once width + 1 pixels are already in
  // flight, or on every effective flush.
  always_comb begin
    if (in_flush) begin
      emit     = (pend_r != '0);
      shift_en = in_xfer & emit;
    end else begin
      emit     = (pend_r == w_r + WIDTH_BITS'(1));
      shift_en = in_xfer;
    end
  end

  assign col_wrap = (WIDTH_BITS'(col_r) == w_r - WIDTH_BITS'(1));
  assign row_wrap = (row_r == h_r - HEIGHT_BITS'(1));
  assign inner    = (row_r != '0) && !row_wrap && (col_r != '0) &&
                    (WIDTH_BITS'(col_r) < (w_r >> 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else if (size_write) begin
      pend_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else if (in_xfer) begin
      if (in_flush && emit) begin
        pend_r <= pend_r - WIDTH_BITS'(1);
      end else if (!in_flush && !emit) begin
        pend_r <= pend_r + WIDTH_BITS'(1);
      end
      if (emit) begin
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_wrap ? '0 : row_r + HEIGHT_BITS'(1);
        end else begin
          col_r <= col_r + COL_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= emit;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_inner_r <= inner;
      s1_last_r  <= col_wrap & row_wrap;
    end
  end

  bts_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (shift_en),
    .shift_bit (in_pixel_in & ~in_flush),
    .width     (w_r),
    .win       (win)
  );

  // Zhang-Suen tests on the window as it stands after the item's shift.
  always_comb begin
    trans = 4'(~win.p2 & win.p3) + 4'(~win.p3 & win.p4) + 4'(~win.p4 & win.p5) +
            4'(~win.p5 & win.p6) + 4'(~win.p6 & win.p7) + 4'(~win.p7 & win.p8) +
            4'(~win.p8 & win.p9) + 4'(~win.p9 & win.p2);
    count = 4'(win.p2) + 4'(win.p3) + 4'(win.p4) + 4'(win.p5) +
            4'(win.p6) + 4'(win.p7) + 4'(win.p8) + 4'(win.p9);
    if (parity_r) begin
      m1 = win.p2 & win.p4 & win.p8;
      m2 = win.p2 & win.p6 & win.p8;
    end else begin
      m1 = win.p2 & win.p4 & win.p6;
      m2 = win.p4 & win.p6 & win.p8;
    end
    rem = s1_inner_r & win.ctr & (trans == TRANS_ONE) &
          (count >= COUNT_LOW) & (count <= COUNT_HIGH) & ~m1 & ~m2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (size_write) begin
      any_r <= 1'b0;
    end else if (s1_go) begin
      any_r <= s1_last_r ? 1'b0 : (any_r | rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pix_out_r <= win.ctr & ~rem;
      rem_out_r <= rem;
      end_out_r <= s1_last_r;
      chg_out_r <= s1_last_r & (any_r | rem);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = pix_out_r;
  assign out_removed       = rem_out_r;
  assign out_frame_end     = end_out_r;
  assign out_frame_changed = chg_out_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= w_r + WIDTH_BITS'(1))
    else $error("pixels in flight exceed width + 1");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WIDTH_BITS'(col_r) < w_r)
    else $error("output column beyond frame width");

  a_changed_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && chg_out_r |-> end_out_r)
    else $error("frame_changed set away from frame end");

  a_removed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rem_out_r |-> !pix_out_r)
    else $error("removed pixel still set");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_last_r) && $stable(s1_inner_r))
    else $error("decision stage overwritten while stalled");

endmodule

// ===== src/bts_window.sv =====
`timescale 1ns / 1ps

module bts_window
  import bts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic                  shift_bit,
  input  logic [WIDTH_BITS-1:0] width,
  output bts_win_t              win
);

  logic mem [LINE_DEPTH];

  logic [LINE_AW-1:0] wp_r;
  logic [LINE_AW-1:0] fill_r;
  logic [LINE_AW-1:0] wp_nxt;
  logic [LINE_AW-1:0] fill_nxt;
  logic [LINE_AW-1:0] dist_w;
  logic [LINE_AW-1:0] dist_2w;
  logic [LINE_AW-1:0] addr_w;
  logic [LINE_AW-1:0] addr_2w;

  logic rd_w_r, rd_2w_r;
  logic vld_w_r, vld_2w_r;
  logic b0_r, b1_r, b2_r;
  logic w1_r, w2_r;
  logic d1_r, d2_r;
  logic tap_w, tap_2w;

  // Taps at w and 2w behind the newest pixel; the neighbors one and two
  // further back are the same taps taken at the previous shifts.
  assign wp_nxt   = wp_r + LINE_AW'(1);
  assign fill_nxt = (&fill_r) ? fill_r : fill_r + LINE_AW'(1);
  assign dist_w   = LINE_AW'(width);
  assign dist_2w  = LINE_AW'({width, 1'b0});
  assign addr_w   = wp_r - dist_w;
  assign addr_2w  = wp_r - dist_2w;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      mem[wp_r] <= shift_bit;
      rd_w_r    <= mem[addr_w];
      rd_2w_r   <= mem[addr_2w];
    end
  end

  // Entries never written read as zero: the fill count tells which exist.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      fill_r   <= '0;
      vld_w_r  <= 1'b0;
      vld_2w_r <= 1'b0;
      b0_r     <= 1'b0;
      b1_r     <= 1'b0;
      b2_r     <= 1'b0;
      w1_r     <= 1'b0;
      w2_r     <= 1'b0;
      d1_r     <= 1'b0;
      d2_r     <= 1'b0;
    end else if (shift_en) begin
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      vld_w_r  <= (dist_w <= fill_r);
      vld_2w_r <= (dist_2w <= fill_r);
      b0_r     <= shift_bit;
      b1_r     <= b0_r;
      b2_r     <= b1_r;
      w1_r     <= tap_w;
      w2_r     <= w1_r;
      d1_r     <= tap_2w;
      d2_r     <= d1_r;
    end
  end

  assign tap_w  = rd_w_r & vld_w_r;
  assign tap_2w = rd_2w_r & vld_2w_r;

  always_comb begin
    win.p5  = b0_r;
    win.p6  = b1_r;
    win.p7  = b2_r;
    win.p4  = tap_w;
    win.ctr = w1_r;
    win.p8  = w2_r;
    win.p3  = tap_2w;
    win.p2  = d1_r;
    win.p9  = d2_r;
  end

endmodule

// ===== test/binary_thinning_subpass_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the streaming thinning sub-pass. An initial block
// builds frames into a queue of pending pixels, a clocked driver offers them
// on the input channel, and a clocked monitor keeps a bit-exact copy of the
// block's window, raster counters and registers. The monitor predicts every
// accepted transfer and compares each output transfer with the oldest
// prediction.
module binary_thinning_subpass_tb;
  import bts_pkg::*;

  // The window holds two rows and three pixels, counting the newest pixel.
  localparam int LINE_BITS = 2 * MAX_WIDTH + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 200;
  localparam int WIDE_PIXELS = 1030;
  localparam int WIDE_FLUSHES = 8;

  // Register index past the end of the register list; writes to it are dropped.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  // A 4x3 frame, first raster pixel in the MSB. The pixel at row 1, column 1
  // has foreground to the north, north-east and east only, so it sits on a
  // single 0-to-1 transition with three neighbours and both products zero.
  localparam logic [11:0] DIRECTED_FRAME = 12'b0110_0110_0000;

  typedef struct packed {
    logic pix;
    logic fl;
  } pix_item_t;

  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic frame_end;
    logic frame_changed;
  } thin_res_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_pixel_in = 1'b0;
  logic                      in_flush = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_pixel_out;
  logic                      out_removed;
  logic                      out_frame_end;
  logic                      out_frame_changed;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Stimulus and expectation stores.
  pix_item_t   pixel_q[$];
  thin_res_t   thinned_q[$];
  int unsigned queued_items = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Idle percentages for each side, and the long receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  pix_item_t drv_item;
  thin_res_t mon_res;
  thin_res_t want;

  // Our copy of the block state. The initial values are the reset state.
  logic [LINE_BITS-1:0]   line_bits = '0;
  logic [WIDTH_BITS-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_RESET;
  logic                   parity_reg = 1'b0;
  int unsigned            in_raster = 0;
  int unsigned            out_raster = 0;
  logic                   frame_cleared = 1'b0;

  binary_thinning_subpass u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_in       (in_pixel_in),
    .in_flush          (in_flush),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_out     (out_pixel_out),
    .out_removed       (out_removed),
    .out_frame_end     (out_frame_end),
    .out_frame_changed (out_frame_changed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // The width in use is clamped to WIDTH_MIN and to what the line buffer can hold.
  function automatic int unsigned used_width();
    if (width_reg < WIDTH_MIN) return 32'(WIDTH_MIN);
    if (width_reg > WIDTH_MAX) return 32'(WIDTH_MAX);
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_height();
    if (height_reg < HEIGHT_MIN) return 32'(HEIGHT_MIN);
    return 32'(height_reg);
  endfunction

  // A size write restarts the frame but keeps the window contents.
  function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
        if (idx == REG_FRAME_WIDTH) width_reg = val[WIDTH_BITS-1:0];
        else height_reg = val[HEIGHT_BITS-1:0];
        in_raster = 0;
        out_raster = 0;
        frame_cleared = 1'b0;
      end
      REG_SUBPASS_PARITY: begin
        parity_reg = val[0];
      end
      default: begin
      end
    endcase
  endfunction

  // Decides the pixel at the center of the window and advances the output
  // raster position.
  function automatic thin_res_t thin_center(int unsigned w, int unsigned total);
    thin_res_t   res;
    logic [7:0]  ring;
    logic        ctr;
    logic        clear;
    logic        prod_a;
    logic        prod_b;
    int unsigned row;
    int unsigned col;
    int unsigned rises;
    int unsigned count;
    row = out_raster / w;
    col = out_raster % w;
    ctr = line_bits[w + 1];
    // Neighbours clockwise from north (P2) round to north-west (P9).
    ring[0] = line_bits[2 * w + 1];
    ring[1] = line_bits[2 * w];
    ring[2] = line_bits[w];
    ring[3] = line_bits[0];
    ring[4] = line_bits[1];
    ring[5] = line_bits[2];
    ring[6] = line_bits[w + 2];
    ring[7] = line_bits[2 * w + 2];
    rises = 0;
    count = 0;
    for (int i = 0; i < 8; i++) begin
      if (!ring[i] && ring[(i + 1) % 8]) rises++;
      count += 32'(ring[i]);
    end
    if (!parity_reg) begin
      prod_a = ring[0] & ring[2] & ring[4];
      prod_b = ring[2] & ring[4] & ring[6];
    end else begin
      prod_a = ring[0] & ring[2] & ring[6];
      prod_b = ring[0] & ring[4] & ring[6];
    end
    // Only the left half of the interior is ever thinned.
    clear = 1'b0;
    if (row >= 1 && row + 1 < total / w && col >= 1 && col < w / 2 &&
        rises == TRANS_ONE && count >= COUNT_LOW && count <= COUNT_HIGH &&
        !prod_a && !prod_b) begin
      clear = ctr;
    end
    if (clear) frame_cleared = 1'b1;
    res.pixel_out = ctr & ~clear;
    res.removed = clear;
    if (out_raster + 1 >= total) begin
      res.frame_end = 1'b1;
      res.frame_changed = frame_cleared;
      out_raster = 0;
      frame_cleared = 1'b0;
    end else begin
      res.frame_end = 1'b0;
      res.frame_changed = 1'b0;
      out_raster++;
    end
    return res;
  endfunction

  // Applies one accepted input transfer. Returns 1 when it yields a result.
  function automatic bit thin_step(input logic pix, input logic fl,
                                   output thin_res_t res);
    int unsigned w;
    int unsigned total;
    int unsigned pend;
    w = used_width();
    total = w * used_height();
    pend = (in_raster >= out_raster) ? in_raster - out_raster
                                     : in_raster + total - out_raster;
    res = '0;
    if (fl) begin
      // A flush with nothing in flight is dropped without touching the window.
      if (pend == 0) return 1'b0;
      line_bits = {line_bits[LINE_BITS-2:0], 1'b0};
      res = thin_center(w, total);
      return 1'b1;
    end
    line_bits = {line_bits[LINE_BITS-2:0], pix};
    in_raster = (in_raster + 1 >= total) ? 0 : in_raster + 1;
    // The first row and one pixel of a stream only fill the window.
    if (pend + 1 > w + 1) begin
      res = thin_center(w, total);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(string name, logic exp_val, logic act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0b, got %0b", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------

  // Offers the next pending pixel. Once valid is up it holds, payload and
  // all, until the transfer happens.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_pixel_in <= drv_item.pix;
        in_flush <= drv_item.fl;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The long hold-off is timed here, apart from the random stalls.
  always @(posedge clk) begin
    if (hold_go) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // The output is checked before this edge's input is predicted: a result
  // never depends on a transfer made at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (thinned_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          fail_count++;
        end else begin
          want = thinned_q.pop_front();
          check_field("pixel_out", want.pixel_out, out_pixel_out);
          check_field("removed", want.removed, out_removed);
          check_field("frame_end", want.frame_end, out_frame_end);
          check_field("frame_changed", want.frame_changed, out_frame_changed);
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        if (thin_step(in_pixel_in, in_flush, mon_res)) begin
          thinned_q.insert(thinned_q.size(), mon_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("binary_thinning_subpass_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers; all queue pushes happen on the falling edge.
  // ---------------------------------------------------------------------

  task automatic push_item(logic bit_val, logic is_flush);
    pix_item_t pend_item;
    pend_item.pix = bit_val;
    pend_item.fl = is_flush;
    pixel_q.insert(pixel_q.size(), pend_item);
    queued_items++;
  endtask

  task automatic queue_flushes(int unsigned n);
    for (int i = 0; i < n; i++) push_item(1'($urandom_range(1)), 1'b1);
  endtask

  // Random pixels with flushes scattered through them, so that frames are
  // cut short and later pixels land out of step with the raster.
  task automatic queue_noise(int unsigned n);
    for (int i = 0; i < n; i++) begin
      push_item(1'($urandom_range(1)), $urandom_range(99) < 15);
    end
  endtask

  // One whole frame: either random pixels at a chosen density or a filled
  // rectangle with a little salt, which thinning eats from the outside.
  task automatic queue_frame(int unsigned w, int unsigned h);
    int unsigned style;
    int unsigned dens;
    int unsigned r0;
    int unsigned r1;
    int unsigned c0;
    int unsigned c1;
    logic        pix;
    style = $urandom_range(1);
    case ($urandom_range(2))
      0: dens = 15;
      1: dens = 50;
      default: dens = 85;
    endcase
    r0 = $urandom_range(h - 1);
    r1 = $urandom_range(h - 1, r0);
    c0 = $urandom_range(w - 1);
    c1 = $urandom_range(w - 1, c0);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (style == 0) pix = $urandom_range(99) < dens;
        else pix = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^ ($urandom_range(99) < 3);
        push_item(pix, 1'b0);
      end
    end
  endtask

  // Waits until every offered pixel has gone in and every predicted result
  // has come out, then lets the output pipeline settle.
  task automatic wait_idle();
    do @(negedge clk); while (pixel_q.size() != 0 || in_valid || thinned_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 55;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 55;
      end
      default: begin
        send_idle_pct = 38;
        recv_stall_pct = 38;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    int unsigned base;
    int unsigned phase;
    int unsigned wv;
    int unsigned hv;
    int unsigned ew;
    int unsigned eh;
    int unsigned nframes;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_mode(0);

    // Straight out of reset nothing is in flight, so a flush is dropped.
    push_item(1'b1, 1'b1);
    wait_idle();

    // Directed frame on a 4x3 geometry. A flush right after the size write
    // is dropped again, then the frame goes in and five flushes drain it.
    write_reg(REG_FRAME_WIDTH, 12'd4);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    write_reg(REG_SUBPASS_PARITY, 12'd0);
    push_item(1'b0, 1'b1);
    for (int i = 11; i >= 0; i--) push_item(DIRECTED_FRAME[i], 1'b0);
    queue_flushes(5);
    wait_idle();

    // Widest frame: all width bits set, with the top data bit dropped and the
    // value clamped to the line buffer size. Just over one row and one pixel
    // go in, so the first results come out, and a few flushes follow. The
    // pixels still in the window are abandoned by the next size write.
    set_mode(1);
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    for (int i = 0; i < WIDE_PIXELS; i++) push_item(1'($urandom_range(1)), 1'b0);
    queue_flushes(WIDE_FLUSHES);
    wait_idle();

    // Tallest frame. Halfway through the sender pauses until every result
    // is back, and a write to an index past the register list must change
    // nothing, not even the raster position.
    set_mode(3);
    write_reg(REG_FRAME_WIDTH, 12'd5);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    queue_frame(5, 8);
    wait_idle();
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom_range(4095)));
    queue_frame(5, 8);
    queue_flushes(6);
    wait_idle();

    // Zero sizes clamp up to the smallest 3x3 frame; two frames back to back
    // so the second drains the first.
    set_mode(2);
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    queue_frame(3, 3);
    queue_frame(3, 3);
    queue_flushes(4);
    wait_idle();

    // Back pressure: the receiver holds off for a long stretch while three
    // frames are on offer, so the block fills and drops in_ready.
    set_mode(0);
    write_reg(REG_FRAME_WIDTH, 12'd6);
    write_reg(REG_FRAME_HEIGHT, 12'd5);
    write_reg(REG_SUBPASS_PARITY, 12'd1);
    queue_frame(6, 5);
    queue_frame(6, 5);
    queue_frame(6, 5);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    queue_flushes(7);
    wait_idle();

    // Random geometries, mostly small. Most phases send whole frames and a
    // proper drain; some send noise with early flushes and a ragged tail.
    // Between frames the sender sometimes pauses, and the parity may change
    // while pixels of the current frame are still waiting in the window.
    base = queued_items;
    phase = 0;
    while (queued_items - base < RANDOM_ITEMS) begin
      set_mode(phase % 4);
      case ($urandom_range(9))
        0: wv = $urandom_range(2);
        8: wv = $urandom_range(40, 11);
        9: wv = 3;
        default: wv = $urandom_range(10, 4);
      endcase
      hv = $urandom_range(7);
      write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(wv));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(hv));
      write_reg(REG_SUBPASS_PARITY, CFG_DATA_BITS'($urandom_range(1)));
      ew = (wv < 3) ? 3 : wv;
      eh = (hv < 3) ? 3 : hv;
      nframes = $urandom_range(3, 1);
      if ($urandom_range(5) == 0) begin
        queue_noise(nframes * ew * eh);
        queue_flushes($urandom_range(ew + 3));
      end else begin
        for (int f = 0; f < nframes; f++) begin
          queue_frame(ew, eh);
          if ($urandom_range(3) == 0) begin
            wait_idle();
            if ($urandom_range(1)) begin
              write_reg(REG_SUBPASS_PARITY, CFG_DATA_BITS'($urandom_range(1)));
            end
          end
        end
        queue_flushes(ew + 1);
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("binary_thinning_subpass_tb: PASS");
    end else begin
      $display("binary_thinning_subpass_tb: FAIL");
    end
    $finish;
  end

endmodule
